### sv/assert_macros.svh
// Assertion macros used by the segment tree top.
// Expects clk, and for RMM_ASSERT also rst_n, in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define RMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/rmmst_pkg.sv
// Shared types, constants and helpers of the range min/max segment tree.
// No dependencies.
package rmmst_pkg;

  localparam int LEAVES  = 1024;
  localparam int LVL_W   = $clog2(LEAVES);
  localparam int NODE_W  = LVL_W + 1;
  localparam int QW      = NODE_W + 1;
  localparam int POS_W   = 10;
  localparam int RANGE_W = 11;
  localparam int DATA_W  = 32;
  localparam int CMP_W   = (RANGE_W > QW) ? RANGE_W : QW;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic [NODE_W-1:0]        node_idx_t;
  typedef logic [QW-1:0]            qidx_t;

  localparam data_t     ID_MAX_MODE = -32'sd2147483647;
  localparam data_t     ID_MIN_MODE = 32'sd2147483647;
  localparam node_idx_t NODE_ROOT   = node_idx_t'(1);
  localparam node_idx_t NODE_LAST   = node_idx_t'(2 * LEAVES - 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_W_LEAF,
    ST_W_RD,
    ST_W_UPD,
    ST_Q_TEST,
    ST_Q_LACC,
    ST_Q_RACC,
    ST_Q_FIN
  } state_t;

  typedef struct packed {
    logic      we;
    node_idx_t waddr;
    data_t     wdata;
    node_idx_t raddr;
  } mem_req_t;

  typedef struct packed {
    data_t a;
    data_t b;
  } comb_req_t;

  function automatic data_t identity(input logic use_min);
    return use_min ? ID_MIN_MODE : ID_MAX_MODE;
  endfunction

endpackage

### sv/range_min_max_segment_tree_top.sv
// Range min/max segment tree over LEAVES signed 32-bit leaves (rmmst_pkg).
// Input channel (in_valid/in_ready): in_op selects a point write of in_value at
// in_position, or a query over the leaves [in_range_start, in_range_end), both
// bounds clamped to LEAVES. A query yields one item on the out_ channel; a
// write yields none. An empty range gives the identity of the current mode.
// cfg_we with cfg_use_minimum picks min (1) or max (0) and refills the tree.
// One item at a time: in_ready stays low while a write walks from its leaf up
// to the root and while a query walks its range, and the next item is taken
// only once the block is back in ST_IDLE. Both walks are paced by the single
// read port of the node RAM, one node read per step, each feeding the one
// shared compare unit.
// After reset, and after every cfg_we, a clear pass writes the identity into
// all 2*LEAVES nodes, one a cycle; in_ready stays low meanwhile.
// A finished result sits in the output register; the next item is accepted
// while it waits, and a further query result holds until out_ready.
// Depends on rmmst_pkg, rmmst_ctrl, rmmst_node_ram, rmmst_combine, assert_macros.svh.
`include "assert_macros.svh"

module range_min_max_segment_tree_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [rmmst_pkg::POS_W-1:0]   in_position,
  input  rmmst_pkg::data_t     in_value,
  input  logic [rmmst_pkg::RANGE_W-1:0] in_range_start,
  input  logic [rmmst_pkg::RANGE_W-1:0] in_range_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rmmst_pkg::data_t     out_range_result,
  input  logic                 cfg_we,
  input  logic                 cfg_use_minimum
);
  import rmmst_pkg::*;

  mem_req_t  mem_req;
  data_t     rdata_r;
  comb_req_t comb_req;
  data_t     comb_y;
  logic      use_min;

  rmmst_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_position      (in_position),
    .in_value         (in_value),
    .in_range_start   (in_range_start),
    .in_range_end     (in_range_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_range_result (out_range_result),
    .cfg_we           (cfg_we),
    .cfg_use_minimum  (cfg_use_minimum),
    .mem_req          (mem_req),
    .rdata_r          (rdata_r),
    .comb_req         (comb_req),
    .comb_y           (comb_y),
    .use_min          (use_min)
  );

  rmmst_node_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rdata_r (rdata_r)
  );

  rmmst_combine u_comb (
    .req     (comb_req),
    .use_min (use_min),
    .y       (comb_y)
  );

  `RMM_ASSERT_ALWAYS(a_rst_starts_clear, !rst_n |=> !in_ready, "ready right after reset")
  `RMM_ASSERT(a_cfg_starts_clear, cfg_we |=> !in_ready, "ready right after a mode write")
  `RMM_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "item taken twice")

endmodule

### sv/rmmst_node_ram.sv
// Node store of the tree: one write port, one read port, registered read data.
// Depends on rmmst_pkg.
module rmmst_node_ram (
  input  logic                clk,
  input  rmmst_pkg::mem_req_t req,
  output rmmst_pkg::data_t    rdata_r
);
  import rmmst_pkg::*;

  data_t mem [2 * LEAVES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

endmodule

### sv/rmmst_combine.sv
// Shared combine unit: signed compare and select, min (a < b) or max (a > b) by mode.
// Depends on rmmst_pkg.
module rmmst_combine (
  input  rmmst_pkg::comb_req_t req,
  input  logic                 use_min,
  output rmmst_pkg::data_t     y
);
  import rmmst_pkg::*;

  data_t a;
  data_t b;
  logic  a_lt_b;

  assign a      = req.a;
  assign b      = req.b;
  assign a_lt_b = (a < b);

  always_comb begin
    if (use_min) begin
      y = a_lt_b ? a : b;
    end else begin
      y = (a > b) ? a : b;
    end
  end

endmodule

### sv/rmmst_ctrl.sv
// Sequencer of the segment tree: clear pass, point write walk, range query walk.
// Depends on rmmst_pkg; drives the node RAM and the shared combine unit.
module rmmst_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_op,
  input  logic [rmmst_pkg::POS_W-1:0]   in_position,
  input  rmmst_pkg::data_t     in_value,
  input  logic [rmmst_pkg::RANGE_W-1:0] in_range_start,
  input  logic [rmmst_pkg::RANGE_W-1:0] in_range_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rmmst_pkg::data_t     out_range_result,
  input  logic                 cfg_we,
  input  logic                 cfg_use_minimum,
  output rmmst_pkg::mem_req_t  mem_req,
  input  rmmst_pkg::data_t     rdata_r,
  output rmmst_pkg::comb_req_t comb_req,
  input  rmmst_pkg::data_t     comb_y,
  output logic                 use_min
);
  import rmmst_pkg::*;

  state_t    state_r, state_nxt;
  logic      use_min_r, use_min_nxt;
  node_idx_t clr_cnt_r, clr_cnt_nxt;
  node_idx_t k_r, k_nxt;
  data_t     left_r, left_nxt;
  data_t     right_r, right_nxt;
  qidx_t     lo_r, lo_nxt;
  qidx_t     hi_r, hi_nxt;
  logic      out_valid_r, out_valid_nxt;
  data_t     out_data_r, out_data_nxt;

  logic [CMP_W-1:0] start_ext, end_ext, leaves_ext, start_cl, end_cl;
  qidx_t     lo_init, hi_init, hi_dec, lo_inc;
  logic      pos_ok;
  logic      out_free;

  assign leaves_ext = CMP_W'(LEAVES);
  assign start_ext  = CMP_W'(in_range_start);
  assign end_ext    = CMP_W'(in_range_end);
  assign start_cl   = (start_ext > leaves_ext) ? leaves_ext : start_ext;
  assign end_cl     = (end_ext > leaves_ext) ? leaves_ext : end_ext;
  assign lo_init    = QW'(start_cl) + QW'(LEAVES);
  assign hi_init    = QW'(end_cl) + QW'(LEAVES);
  assign pos_ok     = (CMP_W'(in_position) < leaves_ext);
  assign hi_dec     = hi_r - QW'(1);
  assign lo_inc     = lo_r + QW'(1);
  assign out_free   = !out_valid_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == NODE_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == OP_QUERY) begin
            state_nxt = ST_Q_TEST;
          end else if (pos_ok) begin
            state_nxt = ST_W_LEAF;
          end
        end
      end
      ST_W_LEAF: state_nxt = ST_W_RD;
      ST_W_RD:   state_nxt = (k_r == NODE_ROOT) ? ST_IDLE : ST_W_UPD;
      ST_W_UPD:  state_nxt = ST_W_RD;
      ST_Q_TEST: begin
        if (lo_r >= hi_r) begin
          state_nxt = ST_Q_FIN;
        end else if (lo_r[0]) begin
          state_nxt = ST_Q_LACC;
        end else if (hi_r[0]) begin
          state_nxt = ST_Q_RACC;
        end
      end
      ST_Q_LACC: state_nxt = hi_r[0] ? ST_Q_RACC : ST_Q_TEST;
      ST_Q_RACC: state_nxt = ST_Q_TEST;
      ST_Q_FIN: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
    // A mode write restarts the clear pass.
    if (cfg_we) state_nxt = ST_CLEAR;
  end

  // Datapath and memory control.
  always_comb begin
    use_min_nxt   = use_min_r;
    clr_cnt_nxt   = clr_cnt_r;
    k_nxt         = k_r;
    left_nxt      = left_r;
    right_nxt     = right_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = k_r;
    mem_req.wdata = left_r;
    mem_req.raddr = k_r ^ NODE_ROOT;
    comb_req.a    = left_r;
    comb_req.b    = rdata_r;
    in_ready      = 1'b0;

    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_cnt_r;
        mem_req.wdata = identity(use_min_r);
        clr_cnt_nxt   = clr_cnt_r + NODE_ROOT;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          left_nxt  = (in_op == OP_WRITE) ? in_value : identity(use_min_r);
          right_nxt = identity(use_min_r);
          k_nxt     = node_idx_t'(LEAVES) + node_idx_t'(in_position);
          lo_nxt    = lo_init;
          hi_nxt    = hi_init;
        end
      end
      ST_W_LEAF: begin
        mem_req.we = 1'b1;
      end
      ST_W_RD: begin
        // Sibling read issued by the default address.
      end
      ST_W_UPD: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = k_r >> 1;
        mem_req.wdata = comb_y;
        left_nxt      = comb_y;
        k_nxt         = k_r >> 1;
      end
      ST_Q_TEST: begin
        mem_req.raddr = lo_r[0] ? lo_r[NODE_W-1:0] : hi_dec[NODE_W-1:0];
        if ((lo_r < hi_r) && !lo_r[0] && !hi_r[0]) begin
          lo_nxt = lo_r >> 1;
          hi_nxt = hi_r >> 1;
        end
      end
      ST_Q_LACC: begin
        mem_req.raddr = hi_dec[NODE_W-1:0];
        left_nxt      = comb_y;
        if (hi_r[0]) begin
          lo_nxt = lo_inc;
        end else begin
          lo_nxt = lo_inc >> 1;
          hi_nxt = hi_r >> 1;
        end
      end
      ST_Q_RACC: begin
        comb_req.a = rdata_r;
        comb_req.b = right_r;
        right_nxt  = comb_y;
        lo_nxt     = lo_r >> 1;
        hi_nxt     = hi_dec >> 1;
      end
      ST_Q_FIN: begin
        comb_req.a = left_r;
        comb_req.b = right_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = comb_y;
        end
      end
      default: begin
      end
    endcase

    if (cfg_we) begin
      use_min_nxt = cfg_use_minimum;
      clr_cnt_nxt = '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_range_result = out_data_r;
  assign use_min          = use_min_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      use_min_r   <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      use_min_r   <= use_min_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    left_r     <= left_nxt;
    right_r    <= right_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### tb/tb.sv
// Testbench for range_min_max_segment_tree_top: point writes and range queries in both modes.
// Keeps its own copy of the tree and checks every query result in order.
// Depends on rmmst_pkg and the segment tree RTL.
`timescale 1ns / 100ps

module tb;
  import rmmst_pkg::*;

  localparam int   STALL_LIMIT   = 20000;
  localparam int   SETTLE_CYCLES = 64;
  localparam int   LONG_HOLD     = 400;
  localparam data_t MOST_NEGATIVE = 32'sh8000_0000;
  localparam data_t MOST_POSITIVE = 32'sh7fff_ffff;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_op = OP_WRITE;
  logic [POS_W-1:0]     in_position = '0;
  data_t                in_value = '0;
  logic [RANGE_W-1:0]   in_range_start = '0;
  logic [RANGE_W-1:0]   in_range_end = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  data_t                out_range_result;
  logic                 cfg_we = 1'b0;
  logic                 cfg_use_minimum = 1'b0;

  // Expected tree contents and mode
  data_t tree_nodes [0:2*LEAVES-1];
  logic  min_mode;
  data_t expected_range_results [$];

  int mismatch_count = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  int window_base = 0;
  bit hold_request = 1'b0;
  int hold_left = 0;
  int ready_style = 0;
  int style_left = 0;

  range_min_max_segment_tree_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_position      (in_position),
    .in_value         (in_value),
    .in_range_start   (in_range_start),
    .in_range_end     (in_range_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_range_result (out_range_result),
    .cfg_we           (cfg_we),
    .cfg_use_minimum  (cfg_use_minimum)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic data_t tree_identity();
    return min_mode ? ID_MIN_MODE : ID_MAX_MODE;
  endfunction

  function automatic data_t tree_combine(input data_t a, input data_t b);
    if (min_mode) begin
      return (a < b) ? a : b;
    end
    return (a > b) ? a : b;
  endfunction

  function automatic void tree_refill();
    for (int i = 0; i < 2 * LEAVES; i++) begin
      tree_nodes[i] = tree_identity();
    end
  endfunction

  function automatic void tree_store(input int unsigned pos, input data_t val);
    int unsigned k;
    if (pos >= LEAVES) begin
      return;
    end
    k = pos + LEAVES;
    tree_nodes[k] = val;
    for (k = k >> 1; k != 0; k = k >> 1) begin
      tree_nodes[k] = tree_combine(tree_nodes[2*k], tree_nodes[2*k+1]);
    end
  endfunction

  function automatic data_t tree_range(input int unsigned lo_in, input int unsigned hi_in);
    int unsigned lo;
    int unsigned hi;
    data_t left;
    data_t right;
    lo = ((lo_in > LEAVES) ? LEAVES : lo_in) + LEAVES;
    hi = ((hi_in > LEAVES) ? LEAVES : hi_in) + LEAVES;
    left = tree_identity();
    right = left;
    while (lo < hi) begin
      if (lo & 1) begin
        left = tree_combine(left, tree_nodes[lo]);
        lo++;
      end
      if (hi & 1) begin
        hi--;
        right = tree_combine(tree_nodes[hi], right);
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return tree_combine(left, right);
  endfunction

  function automatic void note_mismatch(input string what, input data_t want, input data_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("MISMATCH %s: expected %0d (%h) actual %0d (%h)", what, want, want, got, got);
    end
  endfunction

  function automatic data_t random_value();
    case ($urandom_range(0, 9))
      0: return MOST_NEGATIVE;
      1: return MOST_POSITIVE;
      2: return ID_MAX_MODE;
      3, 4: return data_t'(int'($urandom_range(0, 20)) - 10);
      default: return data_t'($urandom);
    endcase
  endfunction

  // One item on the input channel, with bursts and gaps between them
  task automatic send_item(input logic op, input logic [POS_W-1:0] pos, input data_t val,
                           input logic [RANGE_W-1:0] rs, input logic [RANGE_W-1:0] re);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk) in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_op          <= op;
    in_position    <= pos;
    in_value       <= val;
    in_range_start <= rs;
    in_range_end   <= re;
    in_valid       <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    if (op == OP_WRITE) begin
      tree_store(pos, val);
    end else begin
      expected_range_results.push_back(tree_range(rs, re));
    end
  endtask

  task automatic write_leaf(input int pos, input data_t val);
    send_item(OP_WRITE, pos[POS_W-1:0], val, RANGE_W'($urandom), RANGE_W'($urandom));
  endtask

  task automatic query_range(input int rs, input int re);
    send_item(OP_QUERY, POS_W'($urandom), data_t'($urandom), rs[RANGE_W-1:0], re[RANGE_W-1:0]);
  endtask

  task automatic drain_results();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_range_results.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // Mode write refills the tree, so let the block go idle first
  task automatic change_mode(input logic use_min);
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    @(negedge clk);
    cfg_we          <= 1'b1;
    cfg_use_minimum <= use_min;
    @(negedge clk) cfg_we <= 1'b0;
    min_mode = use_min;
    tree_refill();
  endtask

  task automatic random_item();
    int rs;
    int re;
    if ($urandom_range(0, 1) == 0) begin
      if ($urandom_range(0, 4) < 3) begin
        write_leaf(window_base + $urandom_range(0, 63), random_value());
      end else begin
        write_leaf($urandom_range(0, LEAVES - 1), random_value());
      end
    end else begin
      case ($urandom_range(0, 9))
        0: begin
          rs = $urandom_range(0, 2047);
          re = $urandom_range(0, 2047);
        end
        1: begin
          rs = $urandom_range(0, LEAVES);
          re = rs - $urandom_range(0, (rs > 8) ? 8 : rs);
        end
        2, 3, 4, 5: begin
          rs = window_base + $urandom_range(0, 63);
          re = rs + $urandom_range(0, 64);
        end
        6, 7, 8: begin
          rs = $urandom_range(0, LEAVES);
          re = $urandom_range(rs, LEAVES);
        end
        default: begin
          rs = $urandom_range(0, 3);
          re = $urandom_range(LEAVES - 4, 2047);
        end
      endcase
      query_range(rs, re);
    end
  endtask

  task automatic test_reset_state();
    query_range(0, LEAVES);
    query_range(5, 5);
    query_range(10, 3);
  endtask

  task automatic test_extremes();
    send_item(OP_WRITE, '0, MOST_NEGATIVE, '1, '1);
    write_leaf(LEAVES - 1, MOST_POSITIVE);
    write_leaf(512, 0);
    write_leaf(1, -1);
    query_range(0, LEAVES);
    query_range(0, 1);
    query_range(0, 2);
    query_range(1, LEAVES - 1);
  endtask

  task automatic test_range_clamping();
    query_range(LEAVES - 1, 2047);
    query_range(LEAVES, 2047);
    query_range(2047, 0);
    query_range(0, 2047);
  endtask

  task automatic test_mode_switch();
    change_mode(1'b1);
    write_leaf(700, -5);
    query_range(0, LEAVES);
    query_range(0, 700);
    // same mode again must still refill the tree
    change_mode(1'b1);
    query_range(0, LEAVES);
    write_leaf(3, MOST_NEGATIVE);
    query_range(0, 4);
  endtask

  task automatic test_random(input int count);
    window_base = $urandom_range(0, LEAVES - 64);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) == 0) begin
        window_base = $urandom_range(0, LEAVES - 64);
      end
      random_item();
    end
  endtask

  task automatic test_backpressure();
    window_base = $urandom_range(0, LEAVES - 64);
    @(posedge clk) hold_request = 1'b1;
    for (int i = 0; i < 30; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        write_leaf(window_base + $urandom_range(0, 63), random_value());
      end else begin
        query_range(window_base + $urandom_range(0, 31), window_base + $urandom_range(16, 64));
      end
    end
    drain_results();
  endtask

  // Receiver: long hold on request, otherwise a changing stall pattern
  always @(negedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        ready_style = $urandom_range(0, 2);
        style_left = $urandom_range(10, 150);
      end
      style_left--;
      case (ready_style)
        0: out_ready <= 1'b1;
        1: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    data_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_range_results.size() == 0) begin
        note_mismatch("unexpected result", 'x, out_range_result);
      end else begin
        want = expected_range_results.pop_front();
        if (out_range_result !== want) begin
          note_mismatch("range_result", want, out_range_result);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    min_mode = 1'b0;
    tree_refill();
    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_reset_state();
    test_extremes();
    test_range_clamping();
    test_mode_switch();
    test_random(250);
    change_mode(1'b0);
    test_random(250);
    test_backpressure();
    change_mode(1'b1);
    test_random(300);
    change_mode(1'b0);
    test_random(270);

    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_range_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
